// ===== sv/prc_pkg.sv =====
// Shared types, constants and helpers for the polygon rectangle clipper.
package prc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int CNT_W       = $clog2(CW);
  localparam int NSTAGE      = 4;
  localparam int NLVL        = NSTAGE + 1;
  localparam int LVL_W       = $clog2(NLVL);
  localparam int STG_W       = $clog2(NSTAGE);
  localparam int ADDR_W      = STG_W + 2;
  localparam int DATA_W      = 32;

  localparam logic [STG_W-1:0] REG_LEFT   = STG_W'(0);
  localparam logic [STG_W-1:0] REG_RIGHT  = STG_W'(1);
  localparam logic [STG_W-1:0] REG_BOTTOM = STG_W'(2);
  localparam logic [STG_W-1:0] REG_TOP    = STG_W'(3);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic        [CW-1:0] mag_t;
  typedef logic signed [CW:0]   diff_t;

  typedef struct packed {
    logic   start;
    logic   neg;
    mag_t   a;
    mag_t   b;
    mag_t   den;
    coord_t o0;
  } mdu_req_t;

  typedef struct packed {
    logic   done;
    coord_t res;
  } mdu_rsp_t;

  function automatic mag_t mag_of(input diff_t v);
    diff_t n;
    n = v[CW] ? (~v + diff_t'(1)) : v;
    return n[CW-1:0];
  endfunction

endpackage

// ===== sv/prc_ifs.sv =====
// Valid/ready channel interfaces for vertices in and clipped vertices out.
interface prc_in_if import prc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t px;
  coord_t py;
  logic   end_of_contour;
  modport source (output valid, px, py, end_of_contour, input ready);
  modport sink   (input valid, px, py, end_of_contour, output ready);
endinterface

interface prc_out_if import prc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t qx;
  coord_t qy;
  logic   is_vertex;
  logic   last_of_contour;
  modport source (output valid, qx, qy, is_vertex, last_of_contour, input ready);
  modport sink   (input valid, qx, qy, is_vertex, last_of_contour, output ready);
endinterface

// ===== sv/prc_muldiv.sv =====
// Bit-serial multiply then restoring divide: o0 +/- trunc(a*b/den).
module prc_muldiv import prc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mdu_req_t req,
  output mdu_rsp_t rsp
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]      ph_r, ph_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2*CW-1:0] acc_r, acc_nxt;
  mag_t            a_r, a_nxt, bm_r, bm_nxt, den_r, den_nxt;
  logic            neg_r, neg_nxt;
  coord_t          o0_r, o0_nxt;
  logic [CW+1:0]   trial;
  mag_t            q;

  assign q     = acc_r[CW-1:0];
  assign trial = {1'b0, acc_r[2*CW-1:CW], acc_r[CW-1]} - {2'b00, den_r};

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    a_nxt   = a_r;
    bm_nxt  = bm_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    o0_nxt  = o0_r;
    case (ph_r)
      PH_IDLE: begin
        if (req.start) begin
          acc_nxt = '0;
          a_nxt   = req.a;
          bm_nxt  = req.b;
          den_nxt = req.den;
          neg_nxt = req.neg;
          o0_nxt  = req.o0;
          cnt_nxt = '0;
          ph_nxt  = PH_MUL;
        end
      end
      PH_MUL: begin
        acc_nxt = {acc_r[2*CW-2:0], 1'b0} + (bm_r[CW-1] ? {{CW{1'b0}}, a_r} : '0);
        bm_nxt  = {bm_r[CW-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CW-1)) begin
          cnt_nxt = '0;
          ph_nxt  = PH_DIV;
        end
      end
      PH_DIV: begin
        // The partial remainder always stays below the divisor.
        if (!trial[CW+1]) begin
          acc_nxt = {trial[CW-1:0], acc_r[CW-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[2*CW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CW-1)) begin
          ph_nxt = PH_FIN;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_IDLE;
      cnt_r <= '0;
    end else begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    bm_r  <= bm_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    o0_r  <= o0_nxt;
  end

  assign rsp.done = (ph_r == PH_FIN);
  assign rsp.res  = neg_r ? (o0_r - coord_t'(q)) : (o0_r + coord_t'(q));

endmodule

// ===== sv/polygon_rect_clipper.sv =====
// Top level of the polygon rectangle clipper: sequencer, stage state and ports.
//
// Vertices of one contour enter on in_vtx in order; end_of_contour marks the
// last one. Clipped vertices leave on out_vtx; last_of_contour marks the final
// result of a contour, and a contour that clips away entirely yields a single
// transaction with is_vertex low. The four clip bounds are written over the
// APB port (left, right, bottom, top at byte addresses 0, 4, 8, 12); the user
// must write them only while the block is idle, which the block does not
// enforce; reads return the current values. One vertex is handled at a time:
// in_vtx.ready is high only while idle. Each boundary crossing is computed in
// the shared bit-serial multiply/divide unit, which sets the rate.
// Each output transaction is held in the output register until taken; a
// stalled receiver simply halts the sequencer. Synchronous reset clears the
// bounds to the widest rectangle and forgets any partly received contour.
module polygon_rect_clipper import prc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  prc_in_if.sink            in_vtx,
  prc_out_if.source         out_vtx,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EDGE = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  coord_t clip_r [NSTAGE];

  coord_t buf_x_r [NLVL][2], buf_x_nxt [NLVL][2];
  coord_t buf_y_r [NLVL][2], buf_y_nxt [NLVL][2];
  logic [1:0] cnt_r [NLVL], cnt_nxt [NLVL];
  logic [1:0] idx_r [NLVL], idx_nxt [NLVL];

  coord_t first_x_r [NSTAGE], first_x_nxt [NSTAGE];
  coord_t first_y_r [NSTAGE], first_y_nxt [NSTAGE];
  coord_t prev_x_r [NSTAGE], prev_x_nxt [NSTAGE];
  coord_t prev_y_r [NSTAGE], prev_y_nxt [NSTAGE];
  logic [NSTAGE-1:0] started_r, started_nxt;

  logic [STG_W-1:0] el_r, el_nxt;
  coord_t x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic slot_r, slot_nxt;
  logic [LVL_W-1:0] close_r, close_nxt;
  logic last_r, last_nxt, final_r, final_nxt;
  coord_t hold_x_r, hold_x_nxt, hold_y_r, hold_y_nxt;
  logic hold_v_r, hold_v_nxt;

  logic out_valid_r, out_valid_nxt;
  coord_t qx_r, qx_nxt, qy_r, qy_nxt;
  logic isv_r, isv_nxt, lst_r, lst_nxt;

  logic found;
  logic [LVL_W-1:0] sel;
  logic [STG_W-1:0] sel_stg, cls_stg;
  logic [LVL_W-1:0] el_next;
  coord_t vx, vy, bound, c0, c1, o0, o1;
  logic i0, i1;
  diff_t d, t, sp;
  mdu_req_t req;
  mdu_rsp_t rsp;

  prc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Deepest level with a vertex waiting is served first, which keeps order.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int l = 0; l < NLVL; l++) begin
      if (idx_r[l] < cnt_r[l]) begin
        found = 1'b1;
        sel   = LVL_W'(l);
      end
    end
  end

  assign sel_stg = sel[STG_W-1:0];
  assign cls_stg = close_r[STG_W-1:0];
  assign el_next = LVL_W'(el_r) + LVL_W'(1);
  assign vx      = buf_x_r[sel][idx_r[sel][0]];
  assign vy      = buf_y_r[sel][idx_r[sel][0]];

  // Edge geometry for the stage in el_r: c is the tested axis, o the other.
  assign bound = clip_r[el_r];
  assign c0    = el_r[1] ? y0_r : x0_r;
  assign c1    = el_r[1] ? y1_r : x1_r;
  assign o0    = el_r[1] ? x0_r : y0_r;
  assign o1    = el_r[1] ? x1_r : y1_r;
  assign i0    = el_r[0] ? (c0 <= bound) : (c0 >= bound);
  assign i1    = el_r[0] ? (c1 <= bound) : (c1 >= bound);
  assign d     = diff_t'(o1) - diff_t'(o0);
  assign t     = diff_t'(bound) - diff_t'(c0);
  assign sp    = diff_t'(c1) - diff_t'(c0);

  assign req.start = (state_r == ST_EDGE) && (i0 != i1);
  assign req.neg   = d[CW] ^ t[CW] ^ sp[CW];
  assign req.a     = mag_of(d);
  assign req.b     = mag_of(t);
  assign req.den   = mag_of(sp);
  assign req.o0    = o0;

  always_comb begin
    state_nxt   = state_r;
    buf_x_nxt   = buf_x_r;
    buf_y_nxt   = buf_y_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    first_x_nxt = first_x_r;
    first_y_nxt = first_y_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    started_nxt = started_r;
    el_nxt      = el_r;
    x0_nxt      = x0_r;
    y0_nxt      = y0_r;
    x1_nxt      = x1_r;
    y1_nxt      = y1_r;
    slot_nxt    = slot_r;
    close_nxt   = close_r;
    last_nxt    = last_r;
    final_nxt   = final_r;
    hold_x_nxt  = hold_x_r;
    hold_y_nxt  = hold_y_r;
    hold_v_nxt  = hold_v_r;
    out_valid_nxt = out_valid_r;
    qx_nxt      = qx_r;
    qy_nxt      = qy_r;
    isv_nxt     = isv_r;
    lst_nxt     = lst_r;
    case (state_r)
      ST_IDLE: begin
        if (in_vtx.valid) begin
          buf_x_nxt[0][0] = in_vtx.px;
          buf_y_nxt[0][0] = in_vtx.py;
          cnt_nxt[0]      = 2'd1;
          idx_nxt[0]      = 2'd0;
          last_nxt        = in_vtx.end_of_contour;
          close_nxt       = '0;
          state_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          idx_nxt[sel] = idx_r[sel] + 2'd1;
          if (sel == LVL_W'(NSTAGE)) begin
            hold_x_nxt = vx;
            hold_y_nxt = vy;
            hold_v_nxt = 1'b1;
            if (hold_v_r) begin
              qx_nxt        = hold_x_r;
              qy_nxt        = hold_y_r;
              isv_nxt       = 1'b1;
              lst_nxt       = 1'b0;
              final_nxt     = 1'b0;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_EMIT;
            end
          end else begin
            prev_x_nxt[sel_stg] = vx;
            prev_y_nxt[sel_stg] = vy;
            if (!started_r[sel_stg]) begin
              first_x_nxt[sel_stg] = vx;
              first_y_nxt[sel_stg] = vy;
              started_nxt[sel_stg] = 1'b1;
            end else begin
              el_nxt    = sel_stg;
              x0_nxt    = prev_x_r[sel_stg];
              y0_nxt    = prev_y_r[sel_stg];
              x1_nxt    = vx;
              y1_nxt    = vy;
              state_nxt = ST_EDGE;
            end
          end
        end else if (last_r && (close_r != LVL_W'(NSTAGE))) begin
          // Close the contour in one stage once everything above it has drained.
          close_nxt            = close_r + LVL_W'(1);
          started_nxt[cls_stg] = 1'b0;
          if (started_r[cls_stg]) begin
            el_nxt    = cls_stg;
            x0_nxt    = prev_x_r[cls_stg];
            y0_nxt    = prev_y_r[cls_stg];
            x1_nxt    = first_x_r[cls_stg];
            y1_nxt    = first_y_r[cls_stg];
            state_nxt = ST_EDGE;
          end
        end else if (last_r) begin
          qx_nxt        = hold_v_r ? hold_x_r : '0;
          qy_nxt        = hold_v_r ? hold_y_r : '0;
          isv_nxt       = hold_v_r;
          lst_nxt       = 1'b1;
          hold_v_nxt    = 1'b0;
          final_nxt     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EDGE: begin
        cnt_nxt[el_next] = {1'b0, i0} + {1'b0, (i0 != i1)};
        idx_nxt[el_next] = 2'd0;
        buf_x_nxt[el_next][0] = x0_r;
        buf_y_nxt[el_next][0] = y0_r;
        slot_nxt  = i0;
        state_nxt = (i0 != i1) ? ST_WAIT : ST_SCAN;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          buf_x_nxt[el_next][slot_r] = el_r[1] ? rsp.res : bound;
          buf_y_nxt[el_next][slot_r] = el_r[1] ? bound : rsp.res;
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (out_vtx.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = final_r ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      final_r     <= 1'b0;
      close_r     <= '0;
      for (int l = 0; l < NLVL; l++) begin
        cnt_r[l] <= 2'd0;
        idx_r[l] <= 2'd0;
      end
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      final_r     <= final_nxt;
      close_r     <= close_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
    buf_x_r   <= buf_x_nxt;
    buf_y_r   <= buf_y_nxt;
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    el_r      <= el_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    slot_r    <= slot_nxt;
    hold_x_r  <= hold_x_nxt;
    hold_y_r  <= hold_y_nxt;
    qx_r      <= qx_nxt;
    qy_r      <= qy_nxt;
    isv_r     <= isv_nxt;
    lst_r     <= lst_nxt;
  end

  // Clip bounds, written through the APB port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r[REG_LEFT]   <= {1'b1, {(CW-1){1'b0}}};
      clip_r[REG_RIGHT]  <= {1'b0, {(CW-1){1'b1}}};
      clip_r[REG_BOTTOM] <= {1'b1, {(CW-1){1'b0}}};
      clip_r[REG_TOP]    <= {1'b0, {(CW-1){1'b1}}};
    end else if (psel && penable && pwrite && pready) begin
      clip_r[paddr[ADDR_W-1:2]] <= pwdata[CW-1:0];
    end
  end

  assign prdata = DATA_W'(clip_r[paddr[ADDR_W-1:2]]);
  assign pready = 1'b1;

  assign in_vtx.ready            = (state_r == ST_IDLE);
  assign out_vtx.valid           = out_valid_r;
  assign out_vtx.qx              = qx_r;
  assign out_vtx.qy              = qy_r;
  assign out_vtx.is_vertex       = isv_r;
  assign out_vtx.last_of_contour = lst_r;

endmodule

// ===== sv/prc_checker.sv =====
// Port-level checks for the polygon rectangle clipper, bound to the top level.
module prc_checker import prc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t qx,
  input logic   is_vertex,
  input logic   last_of_contour
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a transaction");

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !is_vertex) |-> last_of_contour)
    else $error("empty-contour marker without last flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(qx)))
    else $error("stalled result changed");

endmodule

bind polygon_rect_clipper prc_checker u_prc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_vtx.valid),
  .in_ready        (in_vtx.ready),
  .out_valid       (out_vtx.valid),
  .out_ready       (out_vtx.ready),
  .qx              (out_vtx.qx),
  .is_vertex       (out_vtx.is_vertex),
  .last_of_contour (out_vtx.last_of_contour)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the polygon rectangle clipper.
module tb_top import prc_pkg::*; ();

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  typedef struct {
    logic [31:0] qx;
    logic [31:0] qy;
    logic        isv;
    logic        last;
  } clip_res_t;

  typedef struct {
    int          rect;
    logic [31:0] px;
    logic [31:0] py;
    logic        eoc;
    logic        typed;
    clip_res_t   res;
  } vtx_row_t;

  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam int          ONE  = 65536;
  localparam int          SETTLE_CYCLES = 600;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  prc_in_if  in_if();
  prc_out_if out_if();

  polygon_rect_clipper u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vtx  (in_if),
    .out_vtx (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: bounds in left, right, bottom, top order.
  longint    bound [NSTAGE];
  pt_t       first_pt [NSTAGE];
  pt_t       prev_pt [NSTAGE];
  bit        started [NSTAGE];
  bit        held_valid;
  pt_t       held_pt;
  clip_res_t pending_verts [$];

  int  mismatches;
  bit  quiet;
  bit  hold_req;
  logic [31:0] rects [5][4];
  vtx_row_t    rows [$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic bit keeps(input int s, input pt_t p);
    case (s)
      0: return p.x >= bound[0];
      1: return p.x <= bound[1];
      2: return p.y >= bound[2];
      default: return p.y <= bound[3];
    endcase
  endfunction

  // o0 + trunc((o1-o0)*(e-c0)/(c1-c0)) with an exact wide product.
  function automatic longint cross_at(input longint o0, input longint o1,
                                      input longint c0, input longint c1,
                                      input longint e);
    longint       d, t, sp;
    bit           neg;
    logic [127:0] a, b, den, prod, q;
    sp = c1 - c0;
    if (sp == 0) return o0;
    d = o1 - o0;
    t = e - c0;
    neg = ((d < 0) != (t < 0)) != (sp < 0);
    a = (d < 0) ? 128'(-d) : 128'(d);
    b = (t < 0) ? 128'(-t) : 128'(t);
    den = (sp < 0) ? 128'(-sp) : 128'(sp);
    prod = a * b;
    q = prod / den;
    return neg ? o0 - longint'(q[63:0]) : o0 + longint'(q[63:0]);
  endfunction

  function automatic void clip_edge(input int s, input pt_t p0, input pt_t p1,
                                    ref pt_t lst [$]);
    bit  k0, k1;
    pt_t c;
    k0 = keeps(s, p0);
    k1 = keeps(s, p1);
    if (k0) lst.push_back(p0);
    if (k0 != k1) begin
      if (s < 2) begin
        c.x = bound[s];
        c.y = cross_at(p0.y, p1.y, p0.x, p1.x, bound[s]);
      end else begin
        c.x = cross_at(p0.x, p1.x, p0.y, p1.y, bound[s]);
        c.y = bound[s];
      end
      lst.push_back(c);
    end
  endfunction

  function automatic void push_vert(input pt_t p, input bit isv);
    clip_res_t r;
    r.qx = p.x[31:0];
    r.qy = p.y[31:0];
    r.isv = isv;
    r.last = 1'b0;
    pending_verts.push_back(r);
  endfunction

  // Runs one accepted vertex through the four stages and queues its results.
  function automatic void clip_vertex(input logic [31:0] px, input logic [31:0] py,
                                      input bit eoc);
    pt_t cur [$];
    pt_t nxt [$];
    pt_t p;
    int  cnt;
    p.x = sx(px);
    p.y = sx(py);
    cur.push_back(p);
    for (int s = 0; s < NSTAGE; s++) begin
      nxt.delete();
      foreach (cur[i]) begin
        if (started[s]) begin
          clip_edge(s, prev_pt[s], cur[i], nxt);
        end else begin
          first_pt[s] = cur[i];
          started[s] = 1'b1;
        end
        prev_pt[s] = cur[i];
      end
      if (eoc) begin
        if (started[s]) clip_edge(s, prev_pt[s], first_pt[s], nxt);
        started[s] = 1'b0;
      end
      cur = nxt;
    end
    cnt = pending_verts.size();
    if (!eoc) begin
      if (cur.size() > 0) begin
        if (held_valid) push_vert(held_pt, 1'b1);
        for (int i = 0; i + 1 < cur.size(); i++) push_vert(cur[i], 1'b1);
        held_pt = cur[cur.size() - 1];
        held_valid = 1'b1;
      end
      return;
    end
    if (held_valid) push_vert(held_pt, 1'b1);
    foreach (cur[i]) push_vert(cur[i], 1'b1);
    if (pending_verts.size() == cnt) begin
      p.x = 0;
      p.y = 0;
      push_vert(p, 1'b0);
    end
    pending_verts[pending_verts.size() - 1].last = 1'b1;
    held_valid = 1'b0;
  endfunction

  task automatic wait_idle();
    while (pending_verts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * idx);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    bound[idx] = sx(val);
  endtask

  task automatic load_rect(input logic [31:0] l, input logic [31:0] r,
                           input logic [31:0] b, input logic [31:0] t);
    wait_idle();
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_BOTTOM, b);
    write_reg(REG_TOP, t);
  endtask

  // Offers one vertex and returns at the falling edge after its transaction.
  task automatic send_vtx(input logic [31:0] px, input logic [31:0] py, input bit eoc,
                          input bit typed, input clip_res_t res);
    int cnt;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.px = px;
    in_if.py = py;
    in_if.end_of_contour = eoc;
    do @(posedge clk); while (!in_if.ready);
    cnt = pending_verts.size();
    clip_vertex(px, py, eoc);
    if (typed) begin
      while (pending_verts.size() > cnt) void'(pending_verts.pop_back());
      pending_verts.push_back(res);
    end
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'($urandom_range(0, 60 * ONE)) - 32'(30 * ONE);
  endfunction

  function automatic void add_row(input int rect, input int px, input int py,
                                  input bit eoc);
    vtx_row_t w;
    w.rect = rect;
    w.px = px;
    w.py = py;
    w.eoc = eoc;
    w.typed = 1'b0;
    w.res = '{32'd0, 32'd0, 1'b0, 1'b0};
    rows.push_back(w);
  endfunction

  function automatic void add_typed(input int rect, input int px, input int py,
                                    input clip_res_t res);
    add_row(rect, px, py, 1'b1);
    rows[rows.size() - 1].typed = 1'b1;
    rows[rows.size() - 1].res = res;
  endfunction

  // Output side: ready with random stall bursts, plus one long hold-off.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    clip_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transaction: qx=%h qy=%h is_vertex=%b last=%b",
                   out_if.qx, out_if.qy, out_if.is_vertex, out_if.last_of_contour);
      end else begin
        e = pending_verts.pop_front();
        if (out_if.qx !== e.qx || out_if.qy !== e.qy || out_if.is_vertex !== e.isv ||
            out_if.last_of_contour !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %b %b, got %h %h %b %b",
                     e.qx, e.qy, e.isv, e.last, out_if.qx, out_if.qy,
                     out_if.is_vertex, out_if.last_of_contour);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int          sent;
    int          n;
    logic [31:0] l, r, b, t;
    mismatches = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.px = '0;
    in_if.py = '0;
    in_if.end_of_contour = 1'b0;
    bound[0] = sx(CMIN);
    bound[1] = sx(CMAX);
    bound[2] = sx(CMIN);
    bound[3] = sx(CMAX);
    for (int s = 0; s < NSTAGE; s++) begin
      started[s] = 1'b0;
      first_pt[s] = '{0, 0};
      prev_pt[s] = '{0, 0};
    end
    held_valid = 1'b0;
    held_pt = '{0, 0};

    rects[0] = '{CMIN, CMAX, CMIN, CMAX};
    rects[1] = '{32'(-10 * ONE), 32'(10 * ONE), 32'(-10 * ONE), 32'(10 * ONE)};
    rects[2] = '{32'(10 * ONE), 32'(-10 * ONE), 32'(-10 * ONE), 32'(10 * ONE)};
    rects[3] = '{CMAX, CMAX, CMIN, CMIN};
    rects[4] = '{32'd0, 32'd0, 32'd0, 32'd0};

    // Widest rectangle after reset: everything survives unchanged.
    add_typed(0, CMIN, CMIN, '{CMIN, CMIN, 1'b1, 1'b1});
    add_typed(0, CMAX, CMAX, '{CMAX, CMAX, 1'b1, 1'b1});
    add_row(0, 0, 0, 1'b0);
    add_row(0, CMAX, 0, 1'b0);
    add_row(0, 0, CMIN, 1'b1);
    // A single outside vertex yields the empty-contour marker.
    add_typed(1, 20 * ONE, 0, '{32'd0, 32'd0, 1'b0, 1'b1});
    add_typed(1, 0, 0, '{32'd0, 32'd0, 1'b1, 1'b1});
    add_row(1, -20 * ONE, -5 * ONE, 1'b0);
    add_row(1, 20 * ONE, -5 * ONE, 1'b0);
    add_row(1, 20 * ONE, 5 * ONE, 1'b0);
    add_row(1, -20 * ONE, 5 * ONE + 3, 1'b1);
    add_row(1, 5 * ONE, 5 * ONE, 1'b0);
    add_row(1, 15 * ONE, 5 * ONE + 7, 1'b0);
    add_row(1, 5 * ONE - 1, 15 * ONE, 1'b1);
    // Duplicate vertices pass through unchanged.
    add_row(1, ONE, ONE, 1'b0);
    add_row(1, ONE, ONE, 1'b0);
    add_row(1, 2 * ONE, 3 * ONE, 1'b1);
    add_row(1, 30 * ONE, 30 * ONE, 1'b0);
    add_row(1, 40 * ONE, 30 * ONE, 1'b0);
    add_typed(1, 30 * ONE, 40 * ONE, '{32'd0, 32'd0, 1'b0, 1'b1});
    // Inverted rectangle keeps nothing.
    add_typed(2, 0, 0, '{32'd0, 32'd0, 1'b0, 1'b1});
    add_typed(3, CMAX, CMIN, '{CMAX, CMIN, 1'b1, 1'b1});
    add_row(3, CMIN, CMAX, 1'b0);
    add_row(3, CMAX, CMIN, 1'b1);
    add_row(4, -ONE, -ONE, 1'b0);
    add_row(4, ONE, ONE, 1'b1);

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (i == 0 || rows[i].rect != rows[i - 1].rect)
        load_rect(rects[rows[i].rect][0], rects[rows[i].rect][1],
                  rects[rows[i].rect][2], rects[rows[i].rect][3]);
      send_vtx(rows[i].px, rows[i].py, rows[i].eoc, rows[i].typed, rows[i].res);
    end

    sent = 0;
    while (sent < 450) begin
      if (sent % 60 == 0) begin
        in_if.valid = 1'b0;
        case ($urandom_range(0, 5))
          0: begin
            l = $urandom(); r = $urandom(); b = $urandom(); t = $urandom();
          end
          1: begin
            l = CMIN; r = CMAX; b = CMIN; t = CMAX;
          end
          default: begin
            l = -32'($urandom_range(0, 25 * ONE));
            r = 32'($urandom_range(0, 25 * ONE));
            b = -32'($urandom_range(0, 25 * ONE));
            t = 32'($urandom_range(0, 25 * ONE));
          end
        endcase
        load_rect(l, r, b, t);
      end
      if (sent >= 150 && sent < 160) hold_req = 1'b1;
      if (sent >= 300 && sent < 310) begin
        in_if.valid = 1'b0;
        while (pending_verts.size() != 0) @(negedge clk);
      end
      if (sent >= 370) quiet = 1'b1;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      for (int i = 0; i < n; i++)
        send_vtx(rand_coord(), rand_coord(), i == n - 1, 1'b0,
                 '{32'd0, 32'd0, 1'b0, 1'b0});
      sent += n;
    end
    in_if.valid = 1'b0;

    while (pending_verts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
